@@ rtl/ggasfe_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and header lookup for the gga sentence field extractor
package ggasfe_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // header tracker codes
    localparam logic [2:0] STAGE_HUNT = 3'd0;
    localparam logic [2:0] STAGE_LAST = 3'd5;
    localparam logic [2:0] STAGE_SKIP = 3'd6;

    // body field positions
    localparam logic [3:0] FLD_FIRST = 4'd1;
    localparam logic [3:0] FLD_TIME  = 4'd1;
    localparam logic [3:0] FLD_LAT   = 4'd2;
    localparam logic [3:0] FLD_LATH  = 4'd3;
    localparam logic [3:0] FLD_LON   = 4'd4;
    localparam logic [3:0] FLD_LONH  = 4'd5;
    localparam logic [3:0] FLD_ALT   = 4'd9;
    localparam logic [3:0] FLD_ALTU  = 4'd10;
    localparam logic [3:0] FLD_MAX   = 4'd15;

    localparam logic [2:0] TIME_CHARS = 3'd6;

    // output tag codes
    localparam logic [2:0] TAG_TIME = 3'd0;
    localparam logic [2:0] TAG_LAT  = 3'd1;
    localparam logic [2:0] TAG_LATH = 3'd2;
    localparam logic [2:0] TAG_LON  = 3'd3;
    localparam logic [2:0] TAG_LONH = 3'd4;
    localparam logic [2:0] TAG_ALT  = 3'd5;
    localparam logic [2:0] TAG_ALTU = 3'd6;

    typedef struct packed {
        logic       vld;
        logic [2:0] tag;
        logic [7:0] ch;
        logic       eos;
    } t_result;

    // expected byte at each header position
    function automatic logic [7:0] header_byte(input logic [2:0] stage);
        logic [7:0] b;
        case (stage)
            3'd0:    b = CH_DOLLAR;
            3'd1:    b = CH_G;
            3'd2:    b = CH_P;
            3'd3:    b = CH_G;
            3'd4:    b = CH_G;
            3'd5:    b = CH_A;
            default: b = CH_DOLLAR;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/ggasfe_stream_if.sv @@
`timescale 1ns / 1ps
// valid/ready stream interfaces for the byte input and the field output
interface ggasfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ggasfe_field_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_tag;
    logic [7:0] char_out;
    logic       sentence_end;

    modport source (output valid, output field_tag, output char_out, output sentence_end,
                    input ready);
    modport sink   (input valid, input field_tag, input char_out, input sentence_end,
                    output ready);
endinterface

@@ rtl/gga_sentence_field_extractor_top.sv @@
`timescale 1ns / 1ps
// top level of the gga sentence field extractor
//
// usage
//   i_rx takes one received ascii byte per beat (valid/ready, accepted when
//   both are high). the block hunts for the "$GPGGA" header, drops the byte
//   after it, then splits the body at commas, counting empty fields too.
//   o_fld gives one beat per selected character: field_tag names the field
//   (time, lat, lat hemi, lon, lon hemi, alt, alt unit), char_out the byte.
//   only the first six time characters go out. a carriage return in the
//   body, or right after the header, gives an end beat (tag 0, char 13,
//   sentence_end 1) and rearms the header hunt.
//   a byte accepted into the input register passes the combinational parser
//   decode and lands in the result register when the parser takes it.
//   throughput: one byte per cycle while no result byte waits on a stalled
//   o_fld, set by the parser update between the input and result registers.
//   stall: a byte that gives no result passes even while o_fld is stalled;
//   one that gives a result waits in the input register, and i_rx.ready
//   drops until the result register frees up.
//   reset (i_rst_n low, synchronous): both registers empty, parser hunting.
module gga_sentence_field_extractor_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ggasfe_byte_if.sink    i_rx,
    ggasfe_field_if.source o_fld
);
    import ggasfe_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_result    res;
    logic       out_valid;
    logic       consume;
    logic       in_ready;

    // parser steps when its result, if any, has room downstream
    assign consume  = r_in_valid && (!res.vld || !out_valid || o_fld.ready);
    assign in_ready = !r_in_valid || consume;
    assign i_rx.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    ggasfe_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (r_in_byte),
        .i_advance (consume),
        .o_res     (res)
    );

    ggasfe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume && res.vld),
        .i_res   (res),
        .i_ready (o_fld.ready),
        .o_valid (out_valid),
        .o_tag   (o_fld.field_tag),
        .o_char  (o_fld.char_out),
        .o_eos   (o_fld.sentence_end)
    );

    assign o_fld.valid = out_valid;

    // a held byte stays put until the parser takes it
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && r_in_byte == $past(r_in_byte)))
        else $error("input register lost a byte");

    // a byte without result never waits on the output side
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !res.vld) |-> consume)
        else $error("non-result byte stalled");

    // a stalled output with a pending result blocks new bytes
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && res.vld && out_valid && !o_fld.ready) |-> !in_ready)
        else $error("input accepted while result blocked");

endmodule

@@ rtl/ggasfe_parser.sv @@
`timescale 1ns / 1ps
// header matcher, field counter and per-byte result decode
module ggasfe_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_byte,
    input  logic                 i_advance,
    output ggasfe_pkg::t_result  o_res
);
    import ggasfe_pkg::*;

    logic [2:0] r_stage, n_stage;
    logic       r_in_body, n_in_body;
    logic [3:0] r_field, n_field;
    logic [2:0] r_tchars, n_tchars;
    logic [2:0] stage_eff;
    t_result    res;

    always_comb begin
        n_stage   = r_stage;
        n_in_body = r_in_body;
        n_field   = r_field;
        n_tchars  = r_tchars;
        res       = '{vld: 1'b0, tag: TAG_TIME, ch: i_byte, eos: 1'b0};
        stage_eff = (r_stage > STAGE_LAST) ? STAGE_HUNT : r_stage;

        if (r_in_body) begin
            if (i_byte == CH_CR) begin
                res       = '{vld: 1'b1, tag: TAG_TIME, ch: CH_CR, eos: 1'b1};
                n_stage   = STAGE_HUNT;
                n_in_body = 1'b0;
                n_field   = FLD_FIRST;
                n_tchars  = '0;
            end else if (i_byte == CH_COMMA) begin
                if (r_field < FLD_MAX) begin
                    n_field = r_field + 4'd1;
                end
            end else begin
                case (r_field)
                    FLD_TIME: begin
                        if (r_tchars < TIME_CHARS) begin
                            res.vld  = 1'b1;
                            res.tag  = TAG_TIME;
                            n_tchars = r_tchars + 3'd1;
                        end
                    end
                    FLD_LAT: begin
                        res.vld = 1'b1;
                        res.tag = TAG_LAT;
                    end
                    FLD_LATH: begin
                        res.vld = 1'b1;
                        res.tag = TAG_LATH;
                    end
                    FLD_LON: begin
                        res.vld = 1'b1;
                        res.tag = TAG_LON;
                    end
                    FLD_LONH: begin
                        res.vld = 1'b1;
                        res.tag = TAG_LONH;
                    end
                    FLD_ALT: begin
                        res.vld = 1'b1;
                        res.tag = TAG_ALT;
                    end
                    FLD_ALTU: begin
                        res.vld = 1'b1;
                        res.tag = TAG_ALTU;
                    end
                    default: begin
                        res.vld = 1'b0;
                    end
                endcase
            end
        end else if (r_stage == STAGE_SKIP) begin
            // byte after the header is dropped, unless it ends the sentence
            n_stage  = STAGE_HUNT;
            n_field  = FLD_FIRST;
            n_tchars = '0;
            if (i_byte == CH_CR) begin
                res       = '{vld: 1'b1, tag: TAG_TIME, ch: CH_CR, eos: 1'b1};
                n_in_body = 1'b0;
            end else begin
                n_in_body = 1'b1;
            end
        end else begin
            if (i_byte == header_byte(stage_eff)) begin
                n_stage = (stage_eff == STAGE_LAST) ? STAGE_SKIP : stage_eff + 3'd1;
            end else begin
                n_stage = STAGE_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= STAGE_HUNT;
            r_in_body <= 1'b0;
            r_field   <= FLD_FIRST;
            r_tchars  <= '0;
        end else if (i_advance) begin
            r_stage   <= n_stage;
            r_in_body <= n_in_body;
            r_field   <= n_field;
            r_tchars  <= n_tchars;
        end
    end

    assign o_res = res;

    // end of sentence rearms the hunt
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.vld && res.eos) |=>
            (!r_in_body && r_stage == STAGE_HUNT && r_field == FLD_FIRST && r_tchars == '0))
        else $error("sentence end did not rearm the parser");

    // a comma in the body advances the field count until it saturates
    a_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_in_body && i_byte == CH_COMMA && r_field < FLD_MAX) |=>
            (r_field == $past(r_field) + 4'd1))
        else $error("comma did not advance the field count");

    // header state and body flag never both active
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_stage == STAGE_HUNT && r_tchars <= TIME_CHARS && r_field != 4'd0))
        else $error("body flag set while header tracker busy");

endmodule

@@ rtl/ggasfe_out_reg.sv @@
`timescale 1ns / 1ps
// result register holding one beat for the output channel
module ggasfe_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ggasfe_pkg::t_result  i_res,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [2:0]           o_tag,
    output logic [7:0]           o_char,
    output logic                 o_eos
);
    import ggasfe_pkg::*;

    logic       r_valid, n_valid;
    logic [2:0] r_tag;
    logic [7:0] r_char;
    logic       r_eos;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tag  <= i_res.tag;
            r_char <= i_res.ch;
            r_eos  <= i_res.eos;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_char  = r_char;
    assign o_eos   = r_eos;

    // never overwrite a beat the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_ready))
        else $error("result register overwritten while stalled");

    // a load always carries a result
    a_load_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> i_res.vld)
        else $error("empty result loaded");

    // an end beat always carries carriage return
    a_eos_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_eos) |-> (r_char == CH_CR && r_tag == TAG_TIME))
        else $error("end beat with wrong payload");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the gga sentence field extractor
module tb_top;
    import ggasfe_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 880;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [2:0] tag;
        logic [7:0] ch;
        logic       eos;
    } t_field_beat;

    logic i_clk;
    logic i_rst_n;

    ggasfe_byte_if  rx_if ();
    ggasfe_field_if fld_if ();

    gga_sentence_field_extractor_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_fld   (fld_if)
    );

    // header bytes in match order
    logic [7:0] gga_header [6] = '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A};

    // parser state as the testbench sees it
    logic [2:0] hdr_pos;
    logic       body_on;
    logic [3:0] fld_idx;
    logic [2:0] time_seen;

    t_field_beat field_q [$];

    int  cycle_cnt;
    int  mismatch_cnt;
    int  bytes_sent;
    int  sentences_sent;
    int  beats_checked;
    int  end_beats;
    bit  rx_gaps_on;
    bit  fld_stalls_on;

    initial begin
        i_clk = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_cnt, field_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void rearm_parser();
        hdr_pos   = STAGE_HUNT;
        body_on   = 1'b0;
        fld_idx   = FLD_FIRST;
        time_seen = 3'd0;
    endfunction

    // update the parser state for one accepted byte, queue the beat it yields
    task automatic predict_byte(input logic [7:0] b);
        t_field_beat beat;
        logic        hit;
        hit  = 1'b0;
        beat = '{tag: TAG_TIME, ch: b, eos: 1'b0};
        if (body_on) begin
            if (b == CH_CR) begin
                beat = '{tag: TAG_TIME, ch: CH_CR, eos: 1'b1};
                hit  = 1'b1;
                rearm_parser();
            end else if (b == CH_COMMA) begin
                // empty fields count, position saturates
                if (fld_idx < FLD_MAX) fld_idx = fld_idx + 4'd1;
            end else begin
                hit = 1'b1;
                case (fld_idx)
                    FLD_TIME: begin
                        // only the first few time characters go out
                        if (time_seen < TIME_CHARS) time_seen = time_seen + 3'd1;
                        else hit = 1'b0;
                    end
                    FLD_LAT:  beat.tag = TAG_LAT;
                    FLD_LATH: beat.tag = TAG_LATH;
                    FLD_LON:  beat.tag = TAG_LON;
                    FLD_LONH: beat.tag = TAG_LONH;
                    FLD_ALT:  beat.tag = TAG_ALT;
                    FLD_ALTU: beat.tag = TAG_ALTU;
                    default:  hit = 1'b0;
                endcase
            end
        end else if (hdr_pos == STAGE_SKIP) begin
            // byte after the header is dropped unless it ends the sentence
            if (b == CH_CR) begin
                beat = '{tag: TAG_TIME, ch: CH_CR, eos: 1'b1};
                hit  = 1'b1;
                rearm_parser();
            end else begin
                rearm_parser();
                body_on = 1'b1;
            end
        end else if (b == gga_header[hdr_pos]) begin
            hdr_pos = (hdr_pos == STAGE_LAST) ? STAGE_SKIP : hdr_pos + 3'd1;
        end else begin
            // mismatch goes back to the hunt without a recheck as '$'
            hdr_pos = STAGE_HUNT;
        end
        if (hit) field_q.push_back(beat);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short idles, a few long ones
    function automatic int idle_len();
        if ($urandom_range(99, 0) < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // one input beat: optional idle first, then hold until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (rx_gaps_on && $urandom_range(99, 0) < 40) gap = idle_len();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        predict_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // body character: mostly printable, sometimes any byte but the delimiters
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        if ($urandom_range(99, 0) < 75) return 8'($urandom_range(8'h5A, 8'h2D));
        do c = 8'($urandom_range(255, 0)); while (c == CH_CR || c == CH_COMMA);
        return c;
    endfunction

    // a sentence with random content, sometimes broken on purpose
    task automatic send_sentence();
        int kind;
        int bad_pos;
        int n_fields;
        int len;
        int sep;
        kind    = $urandom_range(99, 0);
        bad_pos = (kind < 10) ? $urandom_range(5, 0) : -1;
        sentences_sent++;
        for (int i = 0; i < 6; i++) begin
            if (i == bad_pos) send_byte(8'($urandom_range(255, 0)));
            else send_byte(gga_header[i]);
        end
        // separator after the header: comma, stray byte, or an immediate end
        sep = $urandom_range(99, 0);
        if (sep < 85) begin
            send_byte(CH_COMMA);
        end else if (sep < 93) begin
            send_byte(body_char());
        end else begin
            send_byte(CH_CR);
            return;
        end
        n_fields = ($urandom_range(99, 0) < 85) ? $urandom_range(14, 1)
                                                : $urandom_range(20, 15);
        for (int f = 1; f <= n_fields; f++) begin
            if (f > 1) send_byte(CH_COMMA);
            if (f == 1) len = $urandom_range(9, 0);
            else if ($urandom_range(99, 0) < 90) len = $urandom_range(4, 0);
            else len = $urandom_range(9, 5);
            repeat (len) send_byte(body_char());
        end
        // a missing terminator runs the next header into this body
        if ($urandom_range(99, 0) < 92) send_byte(CH_CR);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255, 0)));
    endtask

    task automatic wait_drained();
        while (field_q.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls and checking
    // ------------------------------------------------------------------

    initial begin : fld_ready_gen
        int stall_left;
        stall_left   = 0;
        fld_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                fld_if.ready <= 1'b0;
                stall_left--;
            end else begin
                fld_if.ready <= 1'b1;
                if (fld_stalls_on && $urandom_range(99, 0) < 25) stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin : fld_check
        t_field_beat exp_beat;
        if (i_rst_n && fld_if.valid && fld_if.ready) begin
            beats_checked++;
            if (fld_if.sentence_end) end_beats++;
            if (field_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0d: unexpected beat tag=%0d char=%02h end=%0b", cycle_cnt,
                             fld_if.field_tag, fld_if.char_out, fld_if.sentence_end);
            end else begin
                exp_beat = field_q.pop_front();
                if (fld_if.field_tag !== exp_beat.tag || fld_if.char_out !== exp_beat.ch
                        || fld_if.sentence_end !== exp_beat.eos) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0d: mismatch exp %0d/%02h/%0b, got %0d/%02h/%0b",
                                 cycle_cnt, exp_beat.tag, exp_beat.ch, exp_beat.eos,
                                 fld_if.field_tag, fld_if.char_out, fld_if.sentence_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // header hunt: doubled dollar, broken header, cr while hunting, cr after header
    task automatic test_header_cases();
        send_text("$$GPGGA");
        send_byte(CH_CR);
        send_text("$GPGA");
        send_text("$GPGGA");
        send_byte(CH_CR);
    endtask

    // body: stray separator byte, long time field, odd bytes in lat, lat hemi,
    // lon and lon hemi, empty fields, fields past altitude unit and a saturated count
    task automatic test_body_fields();
        send_text("$GPGGAx1234567,");
        send_byte(8'h00);
        send_byte(CH_COMMA);
        send_byte(8'hFF);
        send_text(",$,");
        send_byte(8'h80);
        send_text(",,,,9,U,Z");
        repeat (6) send_byte(CH_COMMA);
        send_byte(8'h7F);
        send_byte(CH_CR);
    endtask

    // mostly well-formed sentences with random content, some broken, some noise
    task automatic test_random_traffic();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            // stretches with and without idles on either side
            rx_gaps_on    = ($urandom_range(99, 0) < 75);
            fld_stalls_on = ($urandom_range(99, 0) < 75);
            if ($urandom_range(99, 0) < 20) send_noise();
            send_sentence();
        end
    endtask

    // sender holds off until every expected beat has come back
    task automatic test_drain_pause();
        rx_gaps_on    = 1'b1;
        fld_stalls_on = 1'b1;
        send_sentence();
        rx_if.valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        send_sentence();
        send_text("$GPGGA,1,2");
        send_byte(CH_CR);
    endtask

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        i_rst_n       = 1'b0;
        cycle_cnt     = 0;
        mismatch_cnt  = 0;
        bytes_sent    = 0;
        sentences_sent = 0;
        beats_checked = 0;
        end_beats     = 0;
        rx_gaps_on    = 1'b0;
        fld_stalls_on = 1'b0;
        rearm_parser();

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_header_cases();
        test_body_fields();
        test_drain_pause();
        test_random_traffic();

        rx_if.valid <= 1'b0;
        wait_drained();
        // nothing further may show up once the queue is empty
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run: %0d bytes in %0d sentences plus noise, %0d beats checked",
                 bytes_sent, sentences_sent, beats_checked);
        $display("run: %0d sentence ends, %0d mismatches", end_beats, mismatch_cnt);
        if (mismatch_cnt == 0 && field_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
